[design/mtde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtde_pkg
// Shared types and constants for the max total distance element block.
// ----------------------------------------------------------------------------
package mtde_pkg;

  // store depth and derived widths
  localparam int MAX_ITEMS = 256;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int SUM_W     = VAL_W + IDX_W;

  // input beat
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } mtde_in_t;

  // result beat
  typedef struct packed {
    logic signed [VAL_W-1:0] farthest_element;
    logic                    dropped;
  } mtde_out_t;

  // control broadcast to every cell
  typedef struct packed {
    logic load;   // shift toward the tail, new element enters cell 0
    logic clr;    // clear accumulators
    logic acc;    // add distance to the broadcast element
    logic drain;  // shift toward cell 0
    logic flush;  // drop all elements
  } mtde_ctl_t;

endpackage

[design/mtde_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtde_cell
// One element slot: holds a value, a valid bit and a distance accumulator,
// shifts with its neighbors during load and drain.
// ----------------------------------------------------------------------------
module mtde_cell
  import mtde_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mtde_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] bcast,
  input  logic signed [VAL_W-1:0] prev_val,
  input  logic                    prev_vld,
  input  logic signed [VAL_W-1:0] next_val,
  input  logic [SUM_W-1:0]        next_acc,
  input  logic                    next_vld,
  output logic signed [VAL_W-1:0] val,
  output logic [SUM_W-1:0]        acc,
  output logic                    vld
);

  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [SUM_W-1:0]        acc_r, acc_nxt;
  logic                    vld_r, vld_nxt;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W-1:0]        abs_diff;

  // absolute difference to the broadcast element
  assign diff     = {val_r[VAL_W-1], val_r} - {bcast[VAL_W-1], bcast};
  assign abs_diff = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];

  // next state
  always_comb begin
    val_nxt = val_r;
    acc_nxt = acc_r;
    vld_nxt = vld_r;
    if (ctl.load) begin
      val_nxt = prev_val;
      vld_nxt = prev_vld;
      acc_nxt = '0;
    end else if (ctl.drain) begin
      val_nxt = next_val;
      vld_nxt = next_vld;
      acc_nxt = next_acc;
    end else if (ctl.acc && vld_r) begin
      acc_nxt = acc_r + SUM_W'(abs_diff);
    end
    if (ctl.clr) begin
      acc_nxt = '0;
    end
    if (ctl.flush) begin
      vld_nxt = 1'b0;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    acc_r <= acc_nxt;
  end

  assign val = val_r;
  assign acc = acc_r;
  assign vld = vld_r;

endmodule

[design/max_total_distance_element.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_total_distance_element
// Collects a set of signed elements and returns the one with the largest
// summed absolute distance to the whole set.
// ----------------------------------------------------------------------------
// Elements load at one per cycle while busy is low; beyond MAX_ITEMS they are
// dropped and the result flags it. The beat with last set closes the set, and
// busy then stays high while the store streams from memory to the row of
// cells, each of which adds its distance to the streamed element, then while
// the totals shift out of cell 0 through a running maximum, and last while
// the result is shown. The result is on out_data for one cycle with out_valid
// high and cannot be held off; ties go to the earliest element.
// ----------------------------------------------------------------------------
module max_total_distance_element
  import mtde_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mtde_in_t  in_data,
  output logic      out_valid,
  output mtde_out_t out_data
);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_ACC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    bc_vld_r;
  logic signed [VAL_W-1:0] bc_data_r;
  logic [SUM_W-1:0]        best_sum_r, best_sum_nxt;
  logic signed [VAL_W-1:0] best_val_r, best_val_nxt;
  logic                    accept;
  logic                    full;
  logic                    rd_en;
  mtde_ctl_t               ctl;

  logic signed [VAL_W-1:0] mem [MAX_ITEMS];

  logic signed [VAL_W-1:0] cell_val [MAX_ITEMS];
  logic [SUM_W-1:0]        cell_acc [MAX_ITEMS];
  logic                    cell_vld [MAX_ITEMS];

  assign busy   = (state_r != S_LOAD);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(MAX_ITEMS));
  assign rd_en  = (state_r == S_ACC) && (ptr_r < count_r);

  // element store
  always_ff @(posedge clk) begin
    if (accept && !full) begin
      mem[count_r[IDX_W-1:0]] <= in_data.value;
    end
    bc_data_r <= mem[ptr_r[IDX_W-1:0]];
  end

  // cell control
  always_comb begin
    ctl       = '0;
    ctl.load  = accept && !full;
    ctl.clr   = accept && in_data.last;
    ctl.acc   = bc_vld_r;
    ctl.drain = (state_r == S_DRAIN);
    ctl.flush = (state_r == S_OUT);
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    ovf_nxt      = ovf_r;
    best_sum_nxt = best_sum_r;
    best_val_nxt = best_val_r;
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_data.last) begin
            ptr_nxt   = '0;
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        if (rd_en) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end else begin
          ptr_nxt      = '0;
          best_sum_nxt = '0;
          state_nxt    = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cell_vld[0] && (cell_acc[0] >= best_sum_r)) begin
          best_sum_nxt = cell_acc[0];
          best_val_nxt = cell_val[0];
        end
        ptr_nxt = ptr_r + CNT_W'(1);
        if (ptr_r == count_r - CNT_W'(1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      count_r  <= '0;
      ptr_r    <= '0;
      ovf_r    <= 1'b0;
      bc_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
      ovf_r    <= ovf_nxt;
      bc_vld_r <= rd_en;
    end
  end

  // running maximum
  always_ff @(posedge clk) begin
    best_sum_r <= best_sum_nxt;
    best_val_r <= best_val_nxt;
  end

  // row of cells
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    logic signed [VAL_W-1:0] pv, nv;
    logic [SUM_W-1:0]        na;
    logic                    pd, nd;
    if (k == 0) begin : g_head
      assign pv = in_data.value;
      assign pd = 1'b1;
    end else begin : g_mid
      assign pv = cell_val[k-1];
      assign pd = cell_vld[k-1];
    end
    if (k == MAX_ITEMS - 1) begin : g_tail
      assign nv = '0;
      assign na = '0;
      assign nd = 1'b0;
    end else begin : g_body
      assign nv = cell_val[k+1];
      assign na = cell_acc[k+1];
      assign nd = cell_vld[k+1];
    end
    mtde_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .bcast    (bc_data_r),
      .prev_val (pv),
      .prev_vld (pd),
      .next_val (nv),
      .next_acc (na),
      .next_vld (nd),
      .val      (cell_val[k]),
      .acc      (cell_acc[k]),
      .vld      (cell_vld[k])
    );
  end

  // result beat
  assign out_valid                 = (state_r == S_OUT);
  assign out_data.farthest_element = best_val_r;
  assign out_data.dropped          = ovf_r;

endmodule

[test/tb_max_total_distance_element.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_total_distance_element
// Self-checking testbench for the max total distance element block.
// ----------------------------------------------------------------------------
// Sets of signed elements go in one beat at a time, each closed by a beat with
// last set. A scoreboard keeps its own copy of the current set, works out the
// element with the largest summed absolute distance (earliest on a tie) and
// whether the set lost elements to a full store. It then checks every result
// beat against the oldest prediction. The stimulus has a few hand-picked sets
// first: single elements, the two extremes, ties and equal elements. Then come
// random sets of mostly small sizes, plus a few that fill or overrun the
// store. Random idle bursts are spread through most of it, but not the closing stretch.
// ----------------------------------------------------------------------------
module tb_max_total_distance_element;
  import mtde_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 1150;
  localparam int TOTAL_BEATS  = 1300;

  // flavor of random element values
  typedef enum int {
    VALS_FULL,
    VALS_NARROW,
    VALS_CORNER,
    VALS_MIXED
  } value_mix_t;

  // predicts the farthest element of each set and checks result beats
  class farthest_scoreboard_t;
    logic signed [VAL_W-1:0] set_values[$];
    bit        set_dropped;
    mtde_out_t expected_farthest[$];
    int        errors;
    int        beats;
    int        results;
    int        dropped_sets;

    function mtde_out_t farthest_of_set();
      mtde_out_t       r;
      longint unsigned best;
      longint unsigned total;
      longint          diff;
      int              best_idx;
      best     = 0;
      best_idx = 0;
      foreach (set_values[i]) begin
        total = 0;
        foreach (set_values[j]) begin
          diff  = longint'(set_values[i]) - longint'(set_values[j]);
          total += (diff < 0) ? -diff : diff;
        end
        // strictly greater keeps the earliest element on a tie
        if (i == 0 || total > best) begin
          best     = total;
          best_idx = i;
        end
      end
      r.farthest_element = set_values[best_idx];
      r.dropped          = set_dropped;
      return r;
    endfunction

    function void note_beat(mtde_in_t beat);
      beats++;
      if (set_values.size() < MAX_ITEMS)
        set_values.push_back(beat.value);
      else
        set_dropped = 1'b1;
      if (beat.last) begin
        expected_farthest.push_back(farthest_of_set());
        if (set_dropped)
          dropped_sets++;
        set_values.delete();
        set_dropped = 1'b0;
      end
    endfunction

    function void check_result(mtde_out_t got);
      mtde_out_t exp_beat;
      results++;
      if (expected_farthest.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual farthest %0d dropped %0b",
                 $time, got.farthest_element, got.dropped);
        errors++;
        return;
      end
      exp_beat = expected_farthest.pop_front();
      if (got.farthest_element !== exp_beat.farthest_element) begin
        $display("%0t: farthest_element mismatch: expected %0d, actual %0d",
                 $time, exp_beat.farthest_element, got.farthest_element);
        errors++;
      end
      if (got.dropped !== exp_beat.dropped) begin
        $display("%0t: dropped mismatch: expected %0b, actual %0b",
                 $time, exp_beat.dropped, got.dropped);
        errors++;
      end
    endfunction

    function int pending();
      return expected_farthest.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  mtde_in_t  in_data = '0;
  logic      out_valid;
  mtde_out_t out_data;

  farthest_scoreboard_t sb = new;
  bit idle_en;
  int cycle_count = 0;

  max_total_distance_element i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_data);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, sb.pending());
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [VAL_W-1:0] gen_value(value_mix_t mix);
    logic signed [VAL_W-1:0] v;
    case (mix)
      VALS_NARROW: begin
        v = int'($urandom_range(0, 6)) - 3;
      end
      VALS_CORNER: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2:       v = 32'sh0000_0000;
          3:       v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      VALS_MIXED: begin
        v = int'($urandom_range(0, 1000));
        if ($urandom_range(0, 1) == 1)
          v = -v;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  // one input beat, with an optional idle burst ahead of it
  task automatic send_beat(logic signed [VAL_W-1:0] v, bit last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start         <= 1'b1;
    in_data.value <= v;
    in_data.last  <= last;
    do @(posedge clk); while (busy);
    sb.note_beat('{value: v, last: last});
  endtask

  task automatic send_list(input logic signed [VAL_W-1:0] vals[$]);
    foreach (vals[k])
      send_beat(vals[k], k == vals.size() - 1);
  endtask

  task automatic send_random_set(int n, value_mix_t mix);
    for (int k = 0; k < n; k++)
      send_beat(gen_value(mix), k == n - 1);
  endtask

  // hold the sender off until every predicted result has come back
  task automatic wait_results_done();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // stimulus
  initial begin
    logic signed [VAL_W-1:0] dir_vals[$];
    int                      set_idx;
    int                      n;

    idle_en = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // single elements at the extremes and zero
    dir_vals = '{32'sh8000_0000};
    send_list(dir_vals);
    dir_vals = '{32'sh7fff_ffff};
    send_list(dir_vals);
    dir_vals = '{32'sh0000_0000};
    send_list(dir_vals);
    // two extremes tie, earliest wins
    dir_vals = '{32'sh8000_0000, 32'sh7fff_ffff};
    send_list(dir_vals);
    dir_vals = '{32'sh7fff_ffff, 32'sh8000_0000};
    send_list(dir_vals);
    // symmetric pair around zero ties
    dir_vals = '{32'sd0, -32'sd1, 32'sd1};
    send_list(dir_vals);
    // all elements equal
    dir_vals = '{32'sd5, 32'sd5, 32'sd5};
    send_list(dir_vals);
    dir_vals = '{32'sh8000_0000, 32'sd0, 32'sh7fff_ffff, -32'sd1};
    send_list(dir_vals);
    dir_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd0};
    send_list(dir_vals);
    wait_results_done();

    // random sets, a few of them filling or overrunning the store
    set_idx = 0;
    while (sb.beats < RANDOM_BEATS) begin
      if (set_idx == 3)
        n = MAX_ITEMS;
      else if (set_idx == 10)
        n = MAX_ITEMS + 1;
      else if (set_idx == 20)
        n = MAX_ITEMS + int'($urandom_range(2, 40));
      else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: n = $urandom_range(1, 8);
          6, 7, 8:          n = $urandom_range(9, 24);
          default:          n = $urandom_range(25, 64);
        endcase
      end
      idle_en = ($urandom_range(0, 3) != 0);
      send_random_set(n, value_mix_t'($urandom_range(0, 3)));
      if (set_idx == 25)
        wait_results_done();
      set_idx++;
    end

    // closing stretch without idling
    idle_en = 1'b0;
    while (sb.beats < TOTAL_BEATS)
      send_random_set($urandom_range(1, 12), value_mix_t'($urandom_range(0, 3)));

    // drain and let the block settle
    wait_results_done();
    repeat (2 * MAX_ITEMS + 8) @(posedge clk);

    $display("summary: %0d element beats in, %0d results checked, %0d sets overran the store",
             sb.beats, sb.results, sb.dropped_sets);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
